>>> hdl/ffha_pkg.sv
// Shared types and constants of the first-fit heap allocator.
`default_nettype none
package ffha_pkg;

    localparam int MAX_BLOCKS_DEF   = 64;
    localparam int HEADER_BYTES_DEF = 5;
    localparam int LEN_W            = 22;
    localparam int ADDR_W           = 32;

    localparam logic [31:0] HEAP_BASE_RST  = 32'h0010_0000;
    localparam logic [31:0] HEAP_LIMIT_RST = 32'h003E_0000;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ZERO    = 2'd1;
    localparam logic [1:0] ST_NOMEM   = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;

    localparam logic KIND_ALLOC   = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    localparam logic REG_HEAP_BASE  = 1'b0;
    localparam logic REG_HEAP_LIMIT = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [LEN_W-1:0]   request_size;
        logic [ADDR_W-1:0]  release_address;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  data_address;
        logic [1:0]         status;
        logic [LEN_W-1:0]   bytes_in_use;
    } rsp_t;

    typedef struct packed {
        logic               used;
        logic [LEN_W-1:0]   len;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_SPLIT_A,
        S_SPLIT_B,
        S_APPEND,
        S_MRG_RD,
        S_MRG_CHK,
        S_MRG_FLUSH,
        S_DONE
    } state_t;

endpackage
`default_nettype wire

>>> hdl/first_fit_heap_allocator.sv
// First-fit heap allocator: request sequencer over the block table.
// Usage:
//   req channel (req_valid/req_stall/req_data) takes one allocate or release
//   beat; rsp channel (rsp_valid/rsp_stall/rsp_data) returns one beat for each.
//   cfg channel (cfg_valid/cfg_ready) writes heap_base (0) or heap_limit (1);
//   cfg_ready is always high; write only while the block is idle.
// Sequencing:
//   One request at a time. The table walk reads one entry per S_RD/S_CHK
//   pair through the single memory read port. Allocate walks to the first
//   free entry that fits, then, on a split, moves the later entries up one
//   slot and writes the two table entries; with no fit it appends at the top.
//   Release walks to the block, then runs a coalescing pass over the table.
//   Zero-size requests answer without a table walk.
//   A new request is taken while a previous response still waits.
// Reset: table empty, heap top and used bytes zero, registers at defaults.
// Stall: a stalled response holds; the sequencer waits with its finished
//   result until the output register is free.
`default_nettype none
module first_fit_heap_allocator #(
    parameter int MAX_BLOCKS   = ffha_pkg::MAX_BLOCKS_DEF,
    parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output      logic          req_stall,
    input  wire ffha_pkg::req_t req_data,
    output      logic          rsp_valid,
    input  wire logic          rsp_stall,
    output ffha_pkg::rsp_t     rsp_data,
    input  wire logic          cfg_valid,
    output      logic          cfg_ready,
    input  wire logic          cfg_index,
    input  wire logic [31:0]   cfg_data
);
    import ffha_pkg::*;

    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [LEN_W-1:0] H22  = LEN_W'(HEADER_BYTES);
    localparam logic [LEN_W-1:0] H22P = LEN_W'(HEADER_BYTES + 1);
    localparam logic [31:0]      H32  = 32'(HEADER_BYTES);
    localparam logic [CW-1:0]    MAXC = CW'(MAX_BLOCKS);

    state_t             state_reg, state_next;
    logic [31:0]        base_reg, limit_reg;
    logic [CW-1:0]      count_reg, count_next;
    logic [LEN_W-1:0]   top_reg, top_next;
    logic [LEN_W-1:0]   used_reg, used_next;
    logic               kind_reg, kind_next;
    logic [LEN_W-1:0]   size_reg, size_next;
    logic [31:0]        rel_reg, rel_next;
    logic [IW-1:0]      idx_reg, idx_next;
    logic [IW-1:0]      j_reg, j_next;
    logic [CW-1:0]      w_reg, w_next;
    logic [LEN_W-1:0]   off_reg, off_next;
    logic [LEN_W-1:0]   fit_len_reg, fit_len_next;
    logic               prev_used_reg, prev_used_next;
    logic [LEN_W-1:0]   prev_len_reg, prev_len_next;
    logic [31:0]        addr_reg, addr_next;
    logic [1:0]         stat_reg, stat_next;
    logic               rsp_valid_next;
    rsp_t               rsp_next;

    logic               wr_en;
    logic [IW-1:0]      wr_addr, rd_addr;
    entry_t             wr_data, rd_data;

    logic [31:0]        blk_addr;
    logic [CW-1:0]      idx_ext, idx_inc;
    logic [23:0]        end_off;
    logic [32:0]        end_abs;
    logic               last_entry;

    ffha_table #(.DEPTH(MAX_BLOCKS), .AW(IW)) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign cfg_ready = 1'b1;
    assign req_stall = (state_reg != S_IDLE);

    assign blk_addr   = base_reg + {{(32-LEN_W){1'b0}}, off_reg} + H32;
    assign idx_ext    = CW'(idx_reg);
    assign idx_inc    = idx_ext + CW'(1);
    assign last_entry = (idx_inc == count_reg);
    assign end_off    = {2'b00, top_reg} + {2'b00, size_reg} + {2'b00, H22};
    assign end_abs    = {1'b0, base_reg} + {9'd0, end_off};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            base_reg  <= HEAP_BASE_RST;
            limit_reg <= HEAP_LIMIT_RST;
            count_reg <= '0;
            top_reg   <= '0;
            used_reg  <= '0;
            rsp_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            top_reg   <= top_next;
            used_reg  <= used_next;
            rsp_valid <= rsp_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_HEAP_BASE)
                begin
                    base_reg <= cfg_data;
                end
                if (cfg_index == REG_HEAP_LIMIT)
                begin
                    limit_reg <= cfg_data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        size_reg      <= size_next;
        rel_reg       <= rel_next;
        idx_reg       <= idx_next;
        j_reg         <= j_next;
        w_reg         <= w_next;
        off_reg       <= off_next;
        fit_len_reg   <= fit_len_next;
        prev_used_reg <= prev_used_next;
        prev_len_reg  <= prev_len_next;
        addr_reg      <= addr_next;
        stat_reg      <= stat_next;
        rsp_data      <= rsp_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        top_next       = top_reg;
        used_next      = used_reg;
        kind_next      = kind_reg;
        size_next      = size_reg;
        rel_next       = rel_reg;
        idx_next       = idx_reg;
        j_next         = j_reg;
        w_next         = w_reg;
        off_next       = off_reg;
        fit_len_next   = fit_len_reg;
        prev_used_next = prev_used_reg;
        prev_len_next  = prev_len_reg;
        addr_next      = addr_reg;
        stat_next      = stat_reg;
        rsp_valid_next = rsp_valid && rsp_stall;
        rsp_next       = rsp_data;
        wr_en          = 1'b0;
        wr_addr        = idx_reg;
        wr_data        = '{used: 1'b0, len: '0};
        rd_addr        = idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    kind_next = req_data.kind;
                    size_next = req_data.request_size;
                    rel_next  = req_data.release_address;
                    idx_next  = '0;
                    off_next  = '0;
                    addr_next = '0;
                    stat_next = ST_OK;
                    if (req_data.kind == KIND_ALLOC && req_data.request_size == '0)
                    begin
                        stat_next  = ST_ZERO;
                        state_next = S_DONE;
                    end
                    else if (count_reg == '0)
                    begin
                        if (req_data.kind == KIND_ALLOC)
                        begin
                            state_next = S_APPEND;
                        end
                        else
                        begin
                            stat_next  = ST_UNKNOWN;
                            state_next = S_DONE;
                        end
                    end
                    else
                    begin
                        state_next = S_RD;
                    end
                end
            end

            S_RD:
            begin
                rd_addr    = idx_reg;
                state_next = S_CHK;
            end

            S_CHK:
            begin
                if (kind_reg == KIND_ALLOC)
                begin
                    if (!rd_data.used && rd_data.len >= size_reg)
                    begin
                        addr_next    = blk_addr;
                        fit_len_next = rd_data.len;
                        if ((rd_data.len - size_reg) >= H22P && count_reg < MAXC)
                        begin
                            if (idx_inc < count_reg)
                            begin
                                j_next     = IW'(count_reg - CW'(1));
                                state_next = S_SHIFT_RD;
                            end
                            else
                            begin
                                state_next = S_SPLIT_A;
                            end
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            wr_addr    = idx_reg;
                            wr_data    = '{used: 1'b1, len: rd_data.len};
                            used_next  = used_reg + rd_data.len + H22;
                            state_next = S_DONE;
                        end
                    end
                    else
                    begin
                        off_next = off_reg + rd_data.len + H22;
                        idx_next = idx_reg + IW'(1);
                        state_next = last_entry ? S_APPEND : S_RD;
                    end
                end
                else
                begin
                    if (blk_addr == rel_reg && rd_data.used)
                    begin
                        wr_en     = 1'b1;
                        wr_addr   = idx_reg;
                        wr_data   = '{used: 1'b0, len: rd_data.len};
                        used_next = (used_reg >= rd_data.len + H22) ?
                                    used_reg - (rd_data.len + H22) : '0;
                        idx_next  = '0;
                        w_next    = '0;
                        state_next = S_MRG_RD;
                    end
                    else
                    begin
                        off_next = off_reg + rd_data.len + H22;
                        idx_next = idx_reg + IW'(1);
                        if (last_entry)
                        begin
                            stat_next  = ST_UNKNOWN;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_RD;
                        end
                    end
                end
            end

            S_SHIFT_RD:
            begin
                rd_addr    = j_reg;
                state_next = S_SHIFT_WR;
            end

            S_SHIFT_WR:
            begin
                wr_en   = 1'b1;
                wr_addr = j_reg + IW'(1);
                wr_data = rd_data;
                if (j_reg == idx_reg + IW'(1))
                begin
                    state_next = S_SPLIT_A;
                end
                else
                begin
                    j_next     = j_reg - IW'(1);
                    state_next = S_SHIFT_RD;
                end
            end

            S_SPLIT_A:
            begin
                wr_en      = 1'b1;
                wr_addr    = idx_reg + IW'(1);
                wr_data    = '{used: 1'b0, len: fit_len_reg - size_reg - H22};
                state_next = S_SPLIT_B;
            end

            S_SPLIT_B:
            begin
                wr_en      = 1'b1;
                wr_addr    = idx_reg;
                wr_data    = '{used: 1'b1, len: size_reg};
                count_next = count_reg + CW'(1);
                used_next  = used_reg + size_reg + H22;
                state_next = S_DONE;
            end

            S_APPEND:
            begin
                if (end_abs >= {1'b0, limit_reg} || end_off[23:LEN_W] != '0
                    || count_reg >= MAXC)
                begin
                    addr_next = '0;
                    stat_next = ST_NOMEM;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = IW'(count_reg);
                    wr_data    = '{used: 1'b1, len: size_reg};
                    count_next = count_reg + CW'(1);
                    addr_next  = base_reg + {{(32-LEN_W){1'b0}}, top_reg} + H32;
                    top_next   = end_off[LEN_W-1:0];
                    used_next  = used_reg + size_reg + H22;
                end
                state_next = S_DONE;
            end

            S_MRG_RD:
            begin
                rd_addr    = idx_reg;
                state_next = S_MRG_CHK;
            end

            S_MRG_CHK:
            begin
                if (w_reg != '0 && !prev_used_reg && !rd_data.used)
                begin
                    prev_len_next = prev_len_reg + H22 + rd_data.len;
                end
                else
                begin
                    if (w_reg != '0)
                    begin
                        wr_en   = 1'b1;
                        wr_addr = IW'(w_reg - CW'(1));
                        wr_data = '{used: prev_used_reg, len: prev_len_reg};
                    end
                    prev_used_next = rd_data.used;
                    prev_len_next  = rd_data.len;
                    w_next         = w_reg + CW'(1);
                end
                idx_next   = idx_reg + IW'(1);
                state_next = last_entry ? S_MRG_FLUSH : S_MRG_RD;
            end

            S_MRG_FLUSH:
            begin
                wr_en      = 1'b1;
                wr_addr    = IW'(w_reg - CW'(1));
                wr_data    = '{used: prev_used_reg, len: prev_len_reg};
                count_next = w_reg;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!rsp_valid || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = '{data_address: addr_reg, status: stat_reg,
                                       bytes_in_use: used_reg};
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> hdl/ffha_table.sv
// Block table memory: one write port, one registered read port.
`default_nettype none
module ffha_table #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic            clk,
    input  wire logic            wr_en,
    input  wire logic [AW-1:0]   wr_addr,
    input  wire ffha_pkg::entry_t wr_data,
    input  wire logic [AW-1:0]   rd_addr,
    output ffha_pkg::entry_t     rd_data
);
    import ffha_pkg::*;

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire
